// File: sv/bsm3_pkg.sv
package bsm3_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int ROWS_MAX      = 4096;

    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int IMG_W_BITS = 12;
    localparam int IMG_H_BITS = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = IMG_W_BITS'(1025);
    localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = IMG_H_BITS'(1025);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = ROW_W + COL_W + SAMPLE_BITS;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // sum of up to nine samples plus rounding bias
    localparam int SUM_W       = SAMPLE_BITS + 4;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(RECIP_ONE);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((RECIP_ONE + 1) / 2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((RECIP_ONE + 2) / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((RECIP_ONE + 3) / 4);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((RECIP_ONE + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((RECIP_ONE + 8) / 9);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t upper;
        sample_t middle;
    } line_pair_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [SUM_W-1:0] biased_sum;
        logic [CNT_W-1:0] count;
        logic             last;
    } emit_t;

    // ceil(2^RECIP_SHIFT / n) for the neighbour counts that can occur
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            CNT_W'(2): m = RECIP_2;
            CNT_W'(3): m = RECIP_3;
            CNT_W'(4): m = RECIP_4;
            CNT_W'(6): m = RECIP_6;
            CNT_W'(9): m = RECIP_9;
            default:   m = RECIP_1;
        endcase
        return m;
    endfunction

endpackage

// File: sv/box_smooth_3x3_edge_aware_unit.sv
// 3x3 mean filter over a raster-order height map with edge-aware divisor: each
// result is the rounded mean of the in-bounds cells around one position, sent
// as soon as its last neighbour has arrived. Two previous rows live in one
// MAX_WIDTH-deep line memory (upper and middle row side by side), read as the
// sample is accepted and written back as it enters the 3x3 window. One sample
// is taken per clock while each sample releases at most one result and the
// divider does not stall; a sample in the last column or last row releases two
// and the final sample of a frame four, and the input then waits for the extra
// results, since one result a cycle leaves the window for the reciprocal
// divider while it has room. Writing image_width or image_height restarts
// the frame at row 0, column 0; do so only while the block is idle.
// The line memory needs no clearing after reset.
module box_smooth_3x3_edge_aware_unit #(
    parameter int MAX_WIDTH = bsm3_pkg::DEF_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] height_sample
    input  logic [bsm3_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [11:0] out_row, [22:12] out_col, [38:23] smoothed, [39] zero
    output logic [bsm3_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [bsm3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsm3_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bsm3_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int EW_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int WCMP     = (EW_BITS > IMG_W_BITS) ? EW_BITS : IMG_W_BITS;

    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    logic [ROW_W-1:0]      row_cnt_reg;
    logic [COL_BITS-1:0]   col_cnt_reg;

    logic [WCMP-1:0]       width_ext;
    logic [EW_BITS-1:0]    eff_w;
    logic [IMG_H_BITS-1:0] eff_h;
    logic                  last_col;
    logic                  last_row;
    logic                  in_accept;

    logic                  v1_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [COL_BITS-1:0]   s1_col_reg;
    sample_t               s1_sample_reg;
    logic                  s1_last_row_reg;
    logic                  s1_last_col_reg;
    logic                  s1_fwd_reg;
    line_pair_t            wlast_reg;
    logic [COL_BITS-1:0]   wlast_addr_reg;
    logic                  s1_move;

    line_pair_t            rd_data;
    line_pair_t            mem_src;
    line_pair_t            wr_data;

    logic                  win_take;
    logic                  emit_valid;
    emit_t                 emit;
    logic                  emit_ready;

    always_comb
    begin
        width_ext = WCMP'(width_reg);
        if (width_ext == '0)
        begin
            eff_w = EW_BITS'(1);
        end
        else if (width_ext > WCMP'(MAX_WIDTH))
        begin
            eff_w = EW_BITS'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_BITS'(width_ext);
        end

        if (height_reg == '0)
        begin
            eff_h = IMG_H_BITS'(1);
        end
        else if (height_reg > IMG_H_BITS'(ROWS_MAX))
        begin
            eff_h = IMG_H_BITS'(ROWS_MAX);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign last_col      = (EW_BITS'(col_cnt_reg) == eff_w - EW_BITS'(1));
    assign last_row      = (IMG_H_BITS'(row_cnt_reg) == eff_h - IMG_H_BITS'(1));
    assign s1_move       = v1_reg && win_take;
    assign s_axis_tready = !v1_reg || s1_move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // config and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_H_BITS-1:0];
                default:          ;
            endcase
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (in_accept)
        begin
            if (last_col)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            v1_reg <= s_axis_tvalid;
        end
    end

    // a read issued in the cycle the previous transaction writes the same
    // entry sees old data; take the written pair instead
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_row_reg      <= row_cnt_reg;
            s1_col_reg      <= col_cnt_reg;
            s1_sample_reg   <= s_axis_tdata[SAMPLE_BITS-1:0];
            s1_last_row_reg <= last_row;
            s1_last_col_reg <= last_col;
            s1_fwd_reg      <= s1_move && (s1_col_reg == col_cnt_reg);
        end
        if (s1_move)
        begin
            wlast_reg      <= wr_data;
            wlast_addr_reg <= s1_col_reg;
        end
    end

    assign mem_src        = s1_fwd_reg ? wlast_reg : rd_data;
    assign wr_data.upper  = mem_src.middle;
    assign wr_data.middle = s1_sample_reg;

    bsm3_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (in_accept),
        .rd_addr (col_cnt_reg),
        .rd_data (rd_data),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    bsm3_window #(
        .COL_BITS (COL_BITS)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_move),
        .in_row      (s1_row_reg),
        .in_col      (s1_col_reg),
        .in_last_row (s1_last_row_reg),
        .in_last_col (s1_last_col_reg),
        .in_lines    (mem_src),
        .in_sample   (s1_sample_reg),
        .take        (win_take),
        .emit_valid  (emit_valid),
        .emit        (emit),
        .emit_ready  (emit_ready)
    );

    bsm3_divide u_divide (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit_valid    (emit_valid),
        .emit          (emit),
        .emit_ready    (emit_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_fwd_addr : assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && s1_fwd_reg) |-> (wlast_addr_reg == s1_col_reg))
        else $error("forwarded line pair belongs to another column");

    a_emit_count : assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> (emit.count == CNT_W'(1) || emit.count == CNT_W'(2) ||
                        emit.count == CNT_W'(3) || emit.count == CNT_W'(4) ||
                        emit.count == CNT_W'(6) || emit.count == CNT_W'(9)))
        else $error("neighbour count is not a rectangle of in-bounds cells");

    a_corner_count : assert property (@(posedge clk) disable iff (!rst_n)
        (emit_valid && emit.last) |-> (emit.count == CNT_W'(1) ||
                                       emit.count == CNT_W'(2) ||
                                       emit.count == CNT_W'(4)))
        else $error("frame corner counted cells beyond the map");

endmodule

// File: sv/bsm3_line_mem.sv
module bsm3_line_mem #(
    parameter int DEPTH = bsm3_pkg::DEF_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output bsm3_pkg::line_pair_t rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  bsm3_pkg::line_pair_t wr_data
);
    import bsm3_pkg::*;

    line_pair_t mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/bsm3_window.sv
module bsm3_window #(
    parameter int COL_BITS = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [bsm3_pkg::ROW_W-1:0]  in_row,
    input  logic [COL_BITS-1:0]         in_col,
    input  logic                        in_last_row,
    input  logic                        in_last_col,
    input  bsm3_pkg::line_pair_t        in_lines,
    input  bsm3_pkg::sample_t           in_sample,
    output logic                        take,
    output logic                        emit_valid,
    output bsm3_pkg::emit_t             emit,
    input  logic                        emit_ready
);
    import bsm3_pkg::*;

    sample_t          win_reg [9];
    logic [3:0]       pending_reg;
    logic [3:0]       pending_next;
    logic [ROW_W-1:0] row_reg;
    logic [COL_BITS-1:0] col_reg;
    logic             r_ge1_reg;
    logic             r_ge2_reg;
    logic             c_ge1_reg;
    logic             c_ge2_reg;
    logic             emit_valid_reg;
    emit_t            emit_reg;
    emit_t            emit_next;

    logic             s3_free;
    logic             issue;
    logic [1:0]       idx;
    logic [2:0]       rows_ok;
    logic [2:0]       cols_ok;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [3:0]       load_mask;

    // pending bits: 0 (r-1,c-1), 1 (r-1,c), 2 (r,c-1), 3 (r,c)
    always_comb
    begin
        idx = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                idx = 2'(i);
            end
        end
    end

    assign s3_free      = !emit_valid_reg || emit_ready;
    assign issue        = (pending_reg != 4'd0) && s3_free;
    assign pending_next = pending_reg & ~(4'b0001 << idx);
    assign take         = (pending_reg == 4'd0) || (issue && (pending_next == 4'd0));

    assign load_mask[0] = (in_row != '0) && (in_col != '0);
    assign load_mask[1] = (in_row != '0) && in_last_col;
    assign load_mask[2] = in_last_row && (in_col != '0);
    assign load_mask[3] = in_last_row && in_last_col;

    always_comb
    begin
        rows_ok = idx[1] ? {1'b1, r_ge1_reg, 1'b0} : {1'b1, 1'b1, r_ge2_reg};
        cols_ok = idx[0] ? {1'b1, c_ge1_reg, 1'b0} : {1'b1, 1'b1, c_ge2_reg};
        sum = '0;
        cnt = '0;
        for (int wr = 0; wr < 3; wr++)
        begin
            for (int wc = 0; wc < 3; wc++)
            begin
                if (rows_ok[wr] && cols_ok[wc])
                begin
                    sum = sum + SUM_W'(win_reg[wr * 3 + wc]);
                    cnt = cnt + CNT_W'(1);
                end
            end
        end
        emit_next.row        = idx[1] ? row_reg : row_reg - ROW_W'(1);
        emit_next.col        = COL_W'(idx[0] ? col_reg : col_reg - COL_BITS'(1));
        emit_next.biased_sum = sum + SUM_W'(cnt >> 1);
        emit_next.count      = cnt;
        emit_next.last       = (idx == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            emit_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (s3_free)
            begin
                emit_valid_reg <= issue;
            end
            if (load)
            begin
                pending_reg <= load_mask;
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k * 3]     <= win_reg[k * 3 + 1];
                    win_reg[k * 3 + 1] <= win_reg[k * 3 + 2];
                end
                win_reg[2] <= in_lines.upper;
                win_reg[5] <= in_lines.middle;
                win_reg[8] <= in_sample;
            end
            else if (issue)
            begin
                pending_reg <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            emit_reg <= emit_next;
        end
        if (load)
        begin
            row_reg   <= in_row;
            col_reg   <= in_col;
            r_ge1_reg <= (in_row != '0);
            r_ge2_reg <= (in_row > ROW_W'(1));
            c_ge1_reg <= (in_col != '0);
            c_ge2_reg <= (in_col > COL_BITS'(1));
        end
    end

    assign emit_valid = emit_valid_reg;
    assign emit       = emit_reg;

endmodule

// File: sv/bsm3_divide.sv
module bsm3_divide (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              emit_valid,
    input  bsm3_pkg::emit_t                   emit,
    output logic                              emit_ready,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bsm3_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast
);
    import bsm3_pkg::*;

    logic [PROD_W-1:0]      product;
    logic                   q_valid_reg;
    logic [ROW_W-1:0]       q_row_reg;
    logic [COL_W-1:0]       q_col_reg;
    sample_t                q_mean_reg;
    logic                   q_last_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;
    logic                   out_free;
    logic                   q_free;

    // exact for every biased sum that fits SUM_W
    assign product    = PROD_W'(emit.biased_sum) * PROD_W'(recip(emit.count));
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign q_free     = !q_valid_reg || out_free;
    assign emit_ready = q_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_free)
            begin
                q_valid_reg <= emit_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= q_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_free && emit_valid)
        begin
            q_row_reg  <= emit.row;
            q_col_reg  <= emit.col;
            q_mean_reg <= product[RECIP_SHIFT +: SAMPLE_BITS];
            q_last_reg <= emit.last;
        end
        if (out_free && q_valid_reg)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, q_mean_reg, q_col_reg, q_row_reg};
            out_last_reg <= q_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
